// ===== rtl/mpp_pkg.sv =====
// Shared widths, request codes and controller/datapath types for the merge path partition block.
package mpp_pkg;

	localparam int LIST_DEPTH_DEF = 256;

	localparam int VAL_W     = 32;
	localparam int LEN_W     = 9;
	localparam int IDX_W     = 8;
	localparam int RANK_W    = 10;
	localparam int REQ_W     = 2;
	localparam int CFG_IDX_W = 1;
	localparam int SIDX_W    = 11;

	localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_LEN_A = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEN_B = 1'd1;

	// Signed search index: covers -1 and every rank and position.
	typedef logic signed [SIDX_W-1:0] sidx_t;

	localparam sidx_t S_ZERO = sidx_t'(0);
	localparam sidx_t S_ONE  = sidx_t'(1);
	localparam sidx_t S_MONE = sidx_t'(-1);

	typedef struct packed {
		logic wr_a;
		logic wr_b;
		logic start;
		logic rd_sc;
		logic take_triv;
		logic take_sc;
		logic set1;
		logic set2;
		logic rd_step;
		logic eval;
		logic fallback;
		logic load_out;
	} mpp_cmd_t;

	typedef struct packed {
		logic triv;
		logic sc_hit;
		logic live;
		logic hit;
	} mpp_stat_t;

endpackage

// ===== rtl/mpp_if.sv =====
// Valid/ready channel interfaces for request beats and result beats.
interface mpp_req_if;
	import mpp_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [REQ_W-1:0]         req_type;
	logic [IDX_W-1:0]         index;
	logic signed [VAL_W-1:0]  value;
	logic [RANK_W-1:0]        rank;

	modport source (output valid, output req_type, output index, output value, output rank,
		input ready);
	modport sink (input valid, input req_type, input index, input value, input rank,
		output ready);
endinterface

interface mpp_res_if;
	import mpp_pkg::*;
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] split_a;
	logic [LEN_W-1:0] split_b;

	modport source (output valid, output split_a, output split_b, input ready);
	modport sink (input valid, input split_a, input split_b, output ready);
endinterface

// ===== rtl/merge_path_partition.sv =====
// Merge path co-rank search over two stored ascending lists, top level.
// A load beat is written to its list RAM at the accepting edge.
// A query first checks the trivial ranks, then the end shortcuts, and otherwise sets up a binary
// search of at most 9 probe steps, each a dual-port RAM read and then a compare. One query is
// worked at a time; an unaccepted result only holds the next query in its final state. Reset
// clears both lengths and the control state; list contents stay undefined until loaded.
module merge_path_partition #(
	parameter int LIST_DEPTH = mpp_pkg::LIST_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mpp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mpp_pkg::LEN_W-1:0]     cfg_data,
	mpp_req_if.sink                       req,
	mpp_res_if.source                     res
);
	import mpp_pkg::*;

	mpp_cmd_t  cmd;
	mpp_stat_t stat;

	mpp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.req_type  (req.req_type),
		.in_ready  (req.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mpp_dp #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.index     (req.index),
		.value     (req.value),
		.rank      (req.rank),
		.cmd       (cmd),
		.stat      (stat),
		.split_a   (res.split_a),
		.split_b   (res.split_b)
	);

endmodule

// ===== rtl/mpp_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module mpp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

// ===== rtl/mpp_ctrl.sv =====
// Controller state machine that sequences loads, shortcut checks and the co-rank search.
module mpp_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [mpp_pkg::REQ_W-1:0] req_type,
	output logic                      in_ready,
	output logic                      out_valid,
	input  logic                      out_ready,
	input  mpp_pkg::mpp_stat_t        stat,
	output mpp_pkg::mpp_cmd_t         cmd
);
	import mpp_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TRIV = 3'd1;
	localparam logic [2:0] ST_SC   = 3'd2;
	localparam logic [2:0] ST_SET1 = 3'd3;
	localparam logic [2:0] ST_SET2 = 3'd4;
	localparam logic [2:0] ST_RD   = 3'd5;
	localparam logic [2:0] ST_EVAL = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.wr_a  = accept && (req_type == REQ_LOAD_A);
				cmd.wr_b  = accept && (req_type == REQ_LOAD_B);
				cmd.start = accept && (req_type == REQ_QUERY);
				if (cmd.start) begin
					state_d = ST_TRIV;
				end
			end
			ST_TRIV: begin
				// Shortcut reads go out here whether or not they are needed.
				cmd.rd_sc = 1'b1;
				if (stat.triv) begin
					cmd.take_triv = 1'b1;
					state_d       = ST_FIN;
				end else begin
					state_d = ST_SC;
				end
			end
			ST_SC: begin
				if (stat.sc_hit) begin
					cmd.take_sc = 1'b1;
					state_d     = ST_FIN;
				end else begin
					state_d = ST_SET1;
				end
			end
			ST_SET1: begin
				cmd.set1 = 1'b1;
				state_d  = ST_SET2;
			end
			ST_SET2: begin
				cmd.set2 = 1'b1;
				state_d  = ST_RD;
			end
			ST_RD: begin
				if (stat.live) begin
					cmd.rd_step = 1'b1;
					state_d     = ST_EVAL;
				end else begin
					cmd.fallback = 1'b1;
					state_d      = ST_FIN;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = stat.hit ? ST_FIN : ST_RD;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/mpp_dp.sv =====
// Datapath: length registers, list RAMs, shortcut compares and the binary search window.
module mpp_dp #(
	parameter int LIST_DEPTH = mpp_pkg::LIST_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mpp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mpp_pkg::LEN_W-1:0]         cfg_data,
	input  logic [mpp_pkg::IDX_W-1:0]         index,
	input  logic signed [mpp_pkg::VAL_W-1:0]  value,
	input  logic [mpp_pkg::RANK_W-1:0]        rank,
	input  mpp_pkg::mpp_cmd_t                 cmd,
	output mpp_pkg::mpp_stat_t                stat,
	output logic [mpp_pkg::LEN_W-1:0]         split_a,
	output logic [mpp_pkg::LEN_W-1:0]         split_b
);
	import mpp_pkg::*;

	localparam int AW = $clog2(LIST_DEPTH);

	logic [LEN_W-1:0]  len_a_q, len_b_q;
	logic [LEN_W-1:0]  na, nb;
	logic [RANK_W-1:0] sum_n;

	logic [LEN_W-1:0]  n1_q, n2_q, off1_q, off2_q;
	logic [RANK_W-1:0] k_q;
	logic              swap_q, half_q;
	sidx_t             left_q, right_q, i_q, j_q;
	logic              bz_q;
	logic [LEN_W-1:0]  r1_q, r2_q;
	logic [LEN_W-1:0]  out_a_q, out_b_q;

	sidx_t n1s, n2s, ks, o1s, o2s;
	sidx_t i_c, j_c, p0, q0;
	sidx_t ia0, ia1, ib0, ib1;
	logic  lt1, lt2;

	logic                    a_we, b_we, idx_ok;
	logic signed [VAL_W-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
	logic signed [VAL_W-1:0] ai, pn, bj, qn;
	sidx_t                   mm1, mm2;
	logic                    c1, c2, c3;
	logic                    sc1, sc2, sc3, sc4;

	sidx_t lo, hi, fa;
	logic  sw, half;
	sidx_t sn1, sn2, d1, d2, o1, o2;
	sidx_t nk, t1, t2, m1, m2, rt;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q <= '0;
			len_b_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LEN_A: len_a_q <= cfg_data;
				CFG_LEN_B: len_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign na    = (32'(len_a_q) > LIST_DEPTH) ? LEN_W'(LIST_DEPTH) : len_a_q;
	assign nb    = (32'(len_b_q) > LIST_DEPTH) ? LEN_W'(LIST_DEPTH) : len_b_q;
	assign sum_n = RANK_W'(na) + RANK_W'(nb);

	assign idx_ok = (32'(index) < LIST_DEPTH);
	assign a_we   = cmd.wr_a && idx_ok;
	assign b_we   = cmd.wr_b && idx_ok;

	assign n1s = sidx_t'(n1_q);
	assign n2s = sidx_t'(n2_q);
	assign ks  = sidx_t'(k_q);
	assign o1s = sidx_t'(off1_q);
	assign o2s = sidx_t'(off2_q);
	assign lt1 = ks < n1s;
	assign lt2 = ks < n2s;

	// Read addresses: the four shortcut probes, or the probe pair of one search step.
	always_comb begin
		i_c = (left_q + right_q) >>> 1;
		j_c = ks - i_c - S_ONE;
		p0  = o1s + i_c;
		q0  = o2s + j_c;
		if (cmd.rd_sc) begin
			ia0 = lt1 ? ks : n1s - S_ONE;
			ib0 = lt1 ? '0 : ks - n1s;
			ia1 = lt2 ? '0 : ks - n2s;
			ib1 = lt2 ? ks : n2s - S_ONE;
		end else if (swap_q) begin
			ia0 = q0;
			ia1 = q0 + S_ONE;
			ib0 = p0;
			ib1 = p0 + S_ONE;
		end else begin
			ia0 = p0;
			ia1 = p0 + S_ONE;
			ib0 = q0;
			ib1 = q0 + S_ONE;
		end
	end

	mpp_ram #(
		.WIDTH (VAL_W),
		.DEPTH (LIST_DEPTH)
	) u_ram_a (
		.clk    (clk),
		.we     (a_we),
		.waddr  (AW'(index)),
		.wdata  (value),
		.raddr0 (AW'(ia0)),
		.raddr1 (AW'(ia1)),
		.rdata0 (a_rd0),
		.rdata1 (a_rd1)
	);

	mpp_ram #(
		.WIDTH (VAL_W),
		.DEPTH (LIST_DEPTH)
	) u_ram_b (
		.clk    (clk),
		.we     (b_we),
		.waddr  (AW'(index)),
		.wdata  (value),
		.raddr0 (AW'(ib0)),
		.raddr1 (AW'(ib1)),
		.rdata0 (b_rd0),
		.rdata1 (b_rd1)
	);

	// Compares for the shortcuts and for one search step.
	always_comb begin
		ai  = swap_q ? b_rd0 : a_rd0;
		pn  = swap_q ? b_rd1 : a_rd1;
		bj  = bz_q ? '0 : (swap_q ? a_rd0 : b_rd0);
		qn  = swap_q ? a_rd1 : b_rd1;
		mm1 = n1s - S_ONE;
		mm2 = n2s - S_ONE;

		c1 = ((j_q == S_MONE) || (ai >= bj)) && ((j_q == mm2) || (ai <= qn));
		c2 = (j_q >= S_ZERO) && (bj >= ai) && ((i_q == mm1) || (bj <= pn));
		c3 = (ai > bj) && (j_q != mm2) && (ai > qn);

		sc1 = lt1 && (a_rd0 <= b_rd0);
		sc2 = !lt1 && (b_rd0 >= a_rd0);
		sc3 = lt2 && (b_rd1 <= a_rd1);
		sc4 = !lt2 && (a_rd1 >= b_rd1);

		stat.triv   = (n1_q == '0) || (n2_q == '0) || (ks >= n1s + n2s);
		stat.sc_hit = sc1 || sc2 || sc3 || sc4;
		stat.live   = (left_q <= right_q);
		stat.hit    = c1 || c2;
	end

	// An exhausted window falls back to the lower bound clamped to the feasible range.
	always_comb begin
		lo = ks - n2s;
		if (lo < S_ZERO) begin
			lo = '0;
		end
		hi = (n1s < ks) ? n1s : ks;
		if (left_q < lo) begin
			fa = lo;
		end else if (left_q > hi) begin
			fa = hi;
		end else begin
			fa = left_q;
		end
	end

	// Search setup: search the shorter list, and shift the window for large ranks.
	always_comb begin
		sw   = n1_q > n2_q;
		sn1  = sw ? n2s : n1s;
		sn2  = sw ? n1s : n2s;
		half = ks < ((n1s + n2s) >>> 1);
		d1   = ks - sn2;
		d2   = ks - sn1;
		o1   = (half || (d1 < S_ZERO)) ? '0 : d1;
		o2   = (half || (d2 < S_ZERO)) ? '0 : d2;

		nk = ks - o1s - o2s;
		t1 = n1s - o1s;
		t2 = n2s - o2s;
		if (half_q) begin
			m1 = n1s;
			m2 = n2s;
			rt = (mm1 < ks) ? mm1 : ks;
		end else begin
			m1 = (t1 < nk + S_ONE) ? t1 : nk + S_ONE;
			m2 = (t2 < nk + S_ONE) ? t2 : nk + S_ONE;
			rt = m1 - S_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			n1_q   <= na;
			n2_q   <= nb;
			k_q    <= (rank > sum_n) ? sum_n : rank;
			swap_q <= 1'b0;
			off1_q <= '0;
			off2_q <= '0;
		end
		if (cmd.take_triv) begin
			if (n1_q == '0) begin
				r1_q <= '0;
				r2_q <= LEN_W'(k_q);
			end else if (n2_q == '0) begin
				r1_q <= LEN_W'(k_q);
				r2_q <= '0;
			end else begin
				r1_q <= n1_q;
				r2_q <= n2_q;
			end
		end
		if (cmd.take_sc) begin
			if (sc1) begin
				r1_q <= LEN_W'(k_q);
				r2_q <= '0;
			end else if (sc2) begin
				r1_q <= n1_q;
				r2_q <= LEN_W'(ks - n1s);
			end else if (sc3) begin
				r1_q <= '0;
				r2_q <= LEN_W'(k_q);
			end else begin
				r1_q <= LEN_W'(ks - n2s);
				r2_q <= n2_q;
			end
		end
		if (cmd.set1) begin
			swap_q <= sw;
			half_q <= half;
			n1_q   <= LEN_W'(sn1);
			n2_q   <= LEN_W'(sn2);
			off1_q <= LEN_W'(o1);
			off2_q <= LEN_W'(o2);
		end
		if (cmd.set2) begin
			k_q     <= RANK_W'(nk);
			n1_q    <= LEN_W'(m1);
			n2_q    <= LEN_W'(m2);
			left_q  <= '0;
			right_q <= rt;
		end
		if (cmd.rd_step) begin
			i_q  <= i_c;
			j_q  <= j_c;
			// The probe just before the start of the list reads as zero.
			bz_q <= (q0 == S_MONE);
		end
		if (cmd.eval) begin
			if (c1) begin
				r1_q <= LEN_W'(i_q);
				r2_q <= LEN_W'(j_q + S_ONE);
			end else if (c2) begin
				r1_q <= LEN_W'(i_q + S_ONE);
				r2_q <= LEN_W'(j_q);
			end else if (c3) begin
				right_q <= i_q - S_ONE;
			end else begin
				left_q <= i_q + S_ONE;
			end
		end
		if (cmd.fallback) begin
			r1_q <= LEN_W'(fa);
			r2_q <= LEN_W'(ks - fa);
		end
		if (cmd.load_out) begin
			out_a_q <= swap_q ? (r2_q + off2_q) : (r1_q + off1_q);
			out_b_q <= swap_q ? (r1_q + off1_q) : (r2_q + off2_q);
		end
	end

	assign split_a = out_a_q;
	assign split_b = out_b_q;

endmodule

// ===== sim/tb.sv =====
// Testbench for merge_path_partition: co-rank queries checked against an in-bench predictor.
`timescale 1ns / 1ps

module tb;
	import mpp_pkg::*;

	localparam int DEPTH         = LIST_DEPTH_DEF;
	localparam int RANDOM_ITEMS  = 1800;
	localparam int SETTLE_CYCLES = 32;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	localparam bit SEL_A = 1'b0;
	localparam bit SEL_B = 1'b1;

	localparam int FILL_SPREAD    = 0;
	localparam int FILL_TIES      = 1;
	localparam int FILL_SCRAMBLED = 2;

	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic [LEN_W-1:0] a;
		logic [LEN_W-1:0] b;
	} split_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LEN_W-1:0]     cfg_data;

	mpp_req_if req_ch ();
	mpp_res_if res_ch ();

	merge_path_partition uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.res       (res_ch)
	);

	// Shadow copy of the block's lists and length registers.
	int               a_words [DEPTH];
	int               b_words [DEPTH];
	logic [LEN_W-1:0] len_a_reg;
	logic [LEN_W-1:0] len_b_reg;

	split_t pending_splits [$];
	int     error_count;
	bit     idle_on;
	int     hold_off;

	always #2 clk = ~clk;

	task automatic flag_error(input string msg);
		error_count++;
		$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	function automatic int word_at(input bit sel, input int pos);
		if (pos < 0 || pos >= DEPTH) begin
			return 0;
		end
		return (sel == SEL_B) ? b_words[pos] : a_words[pos];
	endfunction

	// Binary search over list p against list q, both seen from their offsets.
	function automatic void co_rank_search(input bit p, input int op, input bit q, input int oq,
			input int left, input int right, input int n1, input int n2, input int k,
			output int ra, output int rb);
		int i;
		int j;
		int ai;
		int bj;
		int lo;
		int hi;
		while (left <= right) begin
			i  = (left + right) / 2;
			j  = k - i - 1;
			ai = word_at(p, op + i);
			bj = word_at(q, oq + j);
			if ((j == -1 || ai >= bj) && (j == n2 - 1 || ai <= word_at(q, oq + j + 1))) begin
				ra = i;
				rb = j + 1;
				return;
			end else if (j >= 0 && bj >= ai && (i == n1 - 1 || bj <= word_at(p, op + i + 1))) begin
				ra = i + 1;
				rb = j;
				return;
			end else if (ai > bj && j != n2 - 1 && ai > word_at(q, oq + j + 1)) begin
				right = i - 1;
			end else begin
				left = i + 1;
			end
		end
		// The interval ran dry, which only unsorted lists can cause.
		lo = (k - n2 > 0) ? k - n2 : 0;
		hi = (n1 < k) ? n1 : k;
		ra = (left < lo) ? lo : (left > hi) ? hi : left;
		rb = k - ra;
	endfunction

	function automatic void predict_split(input int k_in, output int sa, output int sb);
		int n1;
		int n2;
		int k;
		int t;
		int r1;
		int r2;
		int off1;
		int off2;
		int nk;
		int m1;
		int m2;
		bit swapped;
		n1 = (len_a_reg > DEPTH) ? DEPTH : int'(len_a_reg);
		n2 = (len_b_reg > DEPTH) ? DEPTH : int'(len_b_reg);
		k  = (k_in > n1 + n2) ? n1 + n2 : k_in;
		sa = 0;
		sb = 0;
		if (n1 == 0) begin
			sb = k;
			return;
		end
		if (n2 == 0) begin
			sa = k;
			return;
		end
		if (k >= n1 + n2) begin
			sa = n1;
			sb = n2;
			return;
		end
		if (k < n1 && word_at(SEL_A, k) <= word_at(SEL_B, 0)) begin
			sa = k;
			return;
		end
		if (k - n1 >= 0 && word_at(SEL_B, k - n1) >= word_at(SEL_A, n1 - 1)) begin
			sa = n1;
			sb = k - n1;
			return;
		end
		if (k < n2 && word_at(SEL_B, k) <= word_at(SEL_A, 0)) begin
			sb = k;
			return;
		end
		if (k - n2 >= 0 && word_at(SEL_A, k - n2) >= word_at(SEL_B, n2 - 1)) begin
			sa = k - n2;
			sb = n2;
			return;
		end
		// The search always runs over the shorter list.
		swapped = (n1 > n2);
		if (swapped) begin
			t  = n1;
			n1 = n2;
			n2 = t;
		end
		if (k < (n1 + n2) / 2) begin
			co_rank_search(swapped, 0, !swapped, 0, 0, (n1 - 1 < k) ? n1 - 1 : k,
				n1, n2, k, r1, r2);
		end else begin
			off1 = (k - n2 > 0) ? k - n2 : 0;
			off2 = (k - n1 > 0) ? k - n1 : 0;
			nk   = k - off1 - off2;
			m1   = (n1 - off1 < nk + 1) ? n1 - off1 : nk + 1;
			m2   = (n2 - off2 < nk + 1) ? n2 - off2 : nk + 1;
			co_rank_search(swapped, off1, !swapped, off2, 0, m1 - 1, m1, m2, nk, r1, r2);
			r1 += off1;
			r2 += off2;
		end
		if (swapped) begin
			sa = r2;
			sb = r1;
		end else begin
			sa = r1;
			sb = r2;
		end
	endfunction

	// Called at the edge that accepts a request beat.
	function automatic void note_beat(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] idx,
			input logic signed [VAL_W-1:0] val, input logic [RANK_W-1:0] rk);
		int     sa;
		int     sb;
		split_t want;
		case (kind)
			REQ_LOAD_A: begin
				if (idx < DEPTH) a_words[idx] = val;
			end
			REQ_LOAD_B: begin
				if (idx < DEPTH) b_words[idx] = val;
			end
			REQ_QUERY: begin
				predict_split(int'(rk), sa, sb);
				want.a = LEN_W'(sa);
				want.b = LEN_W'(sb);
				pending_splits.push_back(want);
			end
			default: begin
			end
		endcase
	endfunction

	task automatic send_beat(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] idx,
			input logic signed [VAL_W-1:0] val, input logic [RANK_W-1:0] rk);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		repeat (gap) @(negedge clk);
		req_ch.valid    = 1'b1;
		req_ch.req_type = kind;
		req_ch.index    = idx;
		req_ch.value    = val;
		req_ch.rank     = rk;
		do @(posedge clk); while (!req_ch.ready);
		note_beat(kind, idx, val, rk);
		@(negedge clk);
		req_ch.valid = 1'b0;
	endtask

	task automatic load_word(input bit sel, input int idx, input logic signed [VAL_W-1:0] val);
		send_beat((sel == SEL_B) ? REQ_LOAD_B : REQ_LOAD_A, IDX_W'(idx), val, RANK_W'($urandom));
	endtask

	task automatic query_rank(input int rk);
		send_beat(REQ_QUERY, IDX_W'($urandom), $urandom, RANK_W'(rk));
	endtask

	// Waits for every outstanding result plus the block's worst-case query time.
	task automatic settle();
		while (pending_splits.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input int data);
		cfg_we    = 1'b1;
		cfg_index = sel;
		cfg_data  = LEN_W'(data);
		if (sel == CFG_LEN_A) len_a_reg = LEN_W'(data);
		else len_b_reg = LEN_W'(data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_lengths(input int na, input int nb);
		settle();
		write_reg(CFG_LEN_A, na);
		write_reg(CFG_LEN_B, nb);
	endtask

	// Writes entries 0 .. n-1 of one list, capped at DEPTH entries; returns the number of beats sent.
	task automatic fill_list(input bit sel, input int n, input int mode, output int beats);
		longint cur;
		int     step_max;
		int     i;
		beats    = (n > DEPTH) ? DEPTH : n;
		step_max = int'(32'hFFFF_FFFF / (beats + 2));
		if (mode == FILL_TIES) cur = longint'($urandom_range(0, 6)) - 3;
		else cur = longint'(VAL_MIN) + longint'($urandom_range(0, step_max));
		for (i = 0; i < beats; i++) begin
			if (mode == FILL_SCRAMBLED) begin
				load_word(sel, i, $urandom);
			end else begin
				load_word(sel, i, VAL_W'(cur));
				if (mode == FILL_TIES) cur += $urandom_range(0, 1);
				else cur += longint'($urandom_range(0, step_max));
			end
		end
	endtask

	// Result sink: random stalls per beat while idle_on is set, plus one long hold-off on request.
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off > 0) begin
				res_ch.ready = 1'b0;
				repeat (hold_off) @(negedge clk);
				hold_off = 0;
			end else if (idle_on) begin
				stall = $urandom_range(0, 3);
				if (stall > 0) begin
					res_ch.ready = 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			res_ch.ready = 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		split_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_splits.size() == 0) begin
				flag_error($sformatf("unexpected result beat (%0d, %0d)",
					res_ch.split_a, res_ch.split_b));
			end else begin
				want = pending_splits.pop_front();
				if (res_ch.split_a !== want.a) begin
					flag_error($sformatf("split_a is %0d, expected %0d", res_ch.split_a, want.a));
				end
				if (res_ch.split_b !== want.b) begin
					flag_error($sformatf("split_b is %0d, expected %0d", res_ch.split_b, want.b));
				end
			end
		end
	end

	task automatic test_empty_lists();
		query_rank(0);
		query_rank(1023);
		send_beat(REQ_UNUSED, IDX_W'($urandom), $urandom, RANK_W'($urandom));
		set_lengths(0, 7);
		query_rank(4);
		query_rank(1023);
		// A length past the store depth acts as the full depth.
		set_lengths(511, 0);
		query_rank(256);
		query_rank(512);
	endtask

	task automatic test_end_shortcuts();
		load_word(SEL_A, 0, VAL_MIN);
		load_word(SEL_A, 1, 4);
		load_word(SEL_A, 2, 4);
		load_word(SEL_B, 0, 4);
		load_word(SEL_B, 1, 9);
		load_word(SEL_B, 2, VAL_MAX);
		set_lengths(3, 3);
		query_rank(2);
		query_rank(4);
		query_rank(6);
		// A now starts above B, which turns the shortcuts around.
		load_word(SEL_A, 0, 5);
		load_word(SEL_A, 1, 9);
		load_word(SEL_A, 2, 9);
		query_rank(0);
		query_rank(3);
		set_lengths(3, 1);
		query_rank(2);
		set_lengths(3, 2);
		query_rank(2);
		query_rank(4);
	endtask

	function automatic int small_len();
		return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
	endfunction

	function automatic int deep_len();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(257, 511) : $urandom_range(1, 256);
	endfunction

	// Each round loads lists (or reuses the full-depth ones), then queries them.
	task automatic test_random_rounds();
		int sent;
		int round;
		int na;
		int nb;
		int mode;
		int nq;
		int span;
		int pick;
		int beats;
		sent = 0;
		for (round = 0; sent < RANDOM_ITEMS; round++) begin
			idle_on = (round % 6 != 5);
			pick    = $urandom_range(0, 19);
			mode    = (pick < 10) ? FILL_SPREAD : (pick < 17) ? FILL_TIES : FILL_SCRAMBLED;
			nq      = $urandom_range(8, 24);
			if (round == 2) begin
				na = DEPTH;
				nb = DEPTH;
				set_lengths(na, nb);
				fill_list(SEL_A, DEPTH, FILL_SPREAD, beats);
				sent += beats;
				fill_list(SEL_B, DEPTH, FILL_SPREAD, beats);
				sent += beats;
				nq = 40;
			end else if (round >= 3 && round <= 8) begin
				na = (round == 3) ? 511 : deep_len();
				nb = (round == 3) ? 511 : deep_len();
				set_lengths(na, nb);
				nq = 40;
				// Hold results back so the block backs up into its request side.
				if (round == 3) hold_off = 150;
			end else begin
				na = small_len();
				nb = small_len();
				set_lengths(na, nb);
				fill_list(SEL_A, na, mode, beats);
				sent += beats;
				fill_list(SEL_B, nb, mode, beats);
				sent += beats;
			end
			span = ((na > DEPTH) ? DEPTH : na) + ((nb > DEPTH) ? DEPTH : nb);
			repeat (nq) begin
				pick = $urandom_range(0, 39);
				if (pick == 0) begin
					send_beat(REQ_UNUSED, IDX_W'($urandom), $urandom, RANK_W'($urandom));
				end else if (pick == 1) begin
					load_word($urandom_range(0, 1), $urandom_range(0, DEPTH - 1), $urandom);
					sent++;
				end else begin
					if ($urandom_range(0, 7) == 0) query_rank($urandom_range(0, 1023));
					else query_rank($urandom_range(0, span));
					sent++;
				end
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_LEN_A;
		cfg_data        = '0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = REQ_LOAD_A;
		req_ch.index    = '0;
		req_ch.value    = '0;
		req_ch.rank     = '0;
		len_a_reg       = '0;
		len_b_reg       = '0;
		error_count     = 0;
		idle_on         = 1'b1;
		hold_off        = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_empty_lists();
		test_end_shortcuts();
		test_random_rounds();
		settle();
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== merge_path_partition.f =====
rtl/mpp_pkg.sv
rtl/mpp_if.sv
rtl/mpp_ram.sv
rtl/mpp_ctrl.sv
rtl/mpp_dp.sv
rtl/merge_path_partition.sv
sim/tb.sv
